[hdl/gmrp_pkg.sv]
package gmrp_pkg;

  // fixed field widths of the stream items
  localparam int IDX_W    = 6;
  localparam int ELEM_W   = 8;
  localparam int IN_ELEMS = 6;
  localparam int PROD_W   = 19;
  localparam int CNT_W    = 7;

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_W = 56;
  localparam int M_DATA_W = 32;

  // item kinds carried on the slave-side tuser
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  // execution sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWI,
    ST_RUN
  } back_state_t;

endpackage

[hdl/gmrp_ram.sv]
module gmrp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port that holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/gmrp_fifo.sv]
module gmrp_fifo #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // pointer wrap at the queue depth
  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  // control: pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue fill count did not follow a push");

endmodule

[hdl/gmrp_front.sv]
module gmrp_front #(
  parameter int MAX_ROWS = 64,
  parameter int COLS     = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gmrp_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,
  output logic                              push,
  output logic [1 + ((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1) +
                COLS * gmrp_pkg::ELEM_W - 1:0] push_data,
  input  logic                              full
);

  import gmrp_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW = COLS * ELEM_W;

  typedef logic [AW-1:0] wrap_tab_t [2**IDX_W];

  // row index folded into the store depth
  function automatic wrap_tab_t build_wrap();
    wrap_tab_t tab;
    int        r;
    for (int k = 0; k < 2**IDX_W; k++) begin
      r = k;
      while (r >= MAX_ROWS) begin
        r = r - MAX_ROWS;
      end
      tab[k] = AW'(r);
    end
    return tab;
  endfunction

  localparam wrap_tab_t WRAP_TAB = build_wrap();

  logic [AW-1:0] row;
  logic [RW-1:0] elems;
  op_t           op;

  assign s_tready = !full;
  assign push     = s_tvalid && s_tready;

  // classify the item and unpack its row
  always_comb begin
    op  = op_t'(s_tuser);
    row = WRAP_TAB[s_tdata[IDX_W-1:0]];
    for (int c = 0; c < COLS; c++) begin
      if (c < IN_ELEMS) begin
        elems[c*ELEM_W +: ELEM_W] = s_tdata[IDX_W + c*ELEM_W +: ELEM_W];
      end else begin
        elems[c*ELEM_W +: ELEM_W] = '0;
      end
    end
  end

  // queue entry: kind in bit 0, then row, then elements
  assign push_data = {elems, row, op};

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("item taken with the queue full");
  assert property (@(posedge clk) disable iff (rst)
    push |-> (row < AW'(MAX_ROWS - 1) || row == AW'(MAX_ROWS - 1)))
    else $error("wrapped row beyond the store");
  assert property (@(posedge clk) disable iff (rst)
    (push && op == OP_COMPUTE) |-> (push_data[0] == 1'b1))
    else $error("compute item queued with the wrong kind");

endmodule

[hdl/gmrp_back.sv]
module gmrp_back #(
  parameter int MAX_ROWS = 64,
  parameter int COLS     = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gmrp_pkg::CNT_W-1:0]        cfg_wdata,
  input  logic                              q_empty,
  input  logic [1 + ((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1) +
                COLS * gmrp_pkg::ELEM_W - 1:0] q_head,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gmrp_pkg::M_DATA_W-1:0]     m_tdata,
  output logic                              m_tlast
);

  import gmrp_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW = COLS * ELEM_W;

  back_state_t state, state_next;

  logic [CNT_W-1:0] rows_in_use;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] run_n;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    row_i;
  logic [RW-1:0]    row_i_data;

  // queue head fields
  op_t           h_op;
  logic [AW-1:0] h_row;
  logic [RW-1:0] h_elems;

  // row store ports
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  // read-data stage and output register
  logic             dvalid;
  logic [CNT_W-1:0] d_col;
  logic             d_last;
  logic             advance;
  logic             issue;
  logic             start;
  logic             run_end;
  logic [PROD_W-1:0] dot;

  logic [IDX_W-1:0]  o_row;
  logic [IDX_W-1:0]  o_col;
  logic [PROD_W-1:0] o_prod;

  assign h_op    = op_t'(q_head[0]);
  assign h_row   = q_head[AW:1];
  assign h_elems = q_head[AW + RW:AW + 1];

  // rows visited per run, capped at the store depth
  assign n_eff = ({2'b00, rows_in_use} > 9'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_in_use;

  assign advance = !m_tvalid || m_tready;
  assign run_end = (cnt + CNT_W'(1) == run_n);

  // rows-in-use register
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CNT_W'(60);
    end else if (cfg_we) begin
      rows_in_use <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty && h_op == OP_COMPUTE && !dvalid && n_eff != '0) begin
          state_next = ST_ROWI;
        end
      end
      ST_ROWI: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (issue && run_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = h_row;
    issue     = 1'b0;
    start     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          if (h_op == OP_LOAD) begin
            q_pop  = 1'b1;
            ram_we = 1'b1;
          end else if (!dvalid) begin
            q_pop  = 1'b1;
            start  = (n_eff != '0);
            ram_re = (n_eff != '0);
          end
        end
      end
      ST_ROWI: begin
      end
      ST_RUN: begin
        issue     = !dvalid || advance;
        ram_re    = issue;
        ram_raddr = AW'(cnt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // run bookkeeping
  always_ff @(posedge clk) begin
    if (start) begin
      row_i <= h_row;
      run_n <= n_eff;
      cnt   <= '0;
    end else if (issue) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (state == ST_ROWI) begin
      row_i_data <= ram_rdata;
    end
    if (issue) begin
      d_col  <= cnt;
      d_last <= run_end;
    end
  end

  gmrp_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (h_row),
    .wdata (h_elems),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // six-term dot product of row i against the row just read
  always_comb begin
    dot = '0;
    for (int c = 0; c < COLS; c++) begin
      dot = dot + PROD_W'(row_i_data[c*ELEM_W +: ELEM_W]) *
                  PROD_W'(ram_rdata[c*ELEM_W +: ELEM_W]);
    end
  end

  // read-data valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
    end else if (issue) begin
      dvalid <= 1'b1;
    end else if (advance) begin
      dvalid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= dvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dvalid) begin
      o_row   <= IDX_W'(row_i);
      o_col   <= IDX_W'(d_col);
      o_prod  <= dot;
      m_tlast <= d_last;
    end
  end

  assign m_tdata = {{(M_DATA_W - 2*IDX_W - PROD_W){1'b0}}, o_prod, o_col, o_row};

  assert property (@(posedge clk) disable iff (rst) (state == ST_ROWI) |=> (state == ST_RUN))
    else $error("row i fetch not followed by the run");
  assert property (@(posedge clk) disable iff (rst) ram_we |-> (state == ST_IDLE && !ram_re))
    else $error("row store written during a run");
  assert property (@(posedge clk) disable iff (rst) issue |-> (cnt < run_n))
    else $error("read issued beyond the rows in use");
  assert property (@(posedge clk) disable iff (rst) start |-> !dvalid)
    else $error("run started with a product still pending");
  assert property (@(posedge clk) disable iff (rst)
    (dvalid && !advance) |=> (dvalid && $stable(ram_rdata)))
    else $error("pending row data lost under stall");

endmodule

[hdl/gram_matrix_row_product_top.sv]
// Gram matrix row engine (A times A transposed, six 8-bit columns per row).
// Slave-side items with tuser = 0 write one row into the row store; items
// with tuser = 1 name row i and produce, for j = 0 .. n-1 with n the rows in
// use (capped at MAX_ROWS), the dot product of rows i and j, tlast marking j
// = n-1; n = 0 produces nothing. Row indexes wrap to the store depth. A
// 4-deep queue sits between the accepting front and the executing back, so
// items are taken while a run streams out. A compute run first fetches row
// i, then yields one result per cycle while m_tready holds, paced by the
// single read port of the row store. The row store is not cleared by reset:
// a row must be written before any run reads it. rows_in_use resets to 60;
// the user must write it through cfg_we / cfg_wdata only while the block is
// idle, and the block itself does not enforce this.
module gram_matrix_row_product_top #(
  parameter int MAX_ROWS = 64,
  parameter int COLS     = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gmrp_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // row_index[5:0], elem0[13:6], elem1[21:14], elem2[29:22], elem3[37:30],
  // elem4[45:38], elem5[53:46], zero[55:54]
  input  logic [gmrp_pkg::S_DATA_W-1:0] s_tdata,
  // opcode[0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_row[5:0], out_col[11:6], product[30:12], zero[31]
  output logic [gmrp_pkg::M_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);

  import gmrp_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int QW = 1 + AW + COLS * ELEM_W;

  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_head;
  logic          q_empty;

  // front: accept and classify items
  gmrp_front #(
    .MAX_ROWS (MAX_ROWS),
    .COLS     (COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  // queue between front and back
  gmrp_fifo #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // back: row store, run sequencer and output register
  gmrp_back #(
    .MAX_ROWS (MAX_ROWS),
    .COLS     (COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
